// ===== design/hll_register_sketch_macros.svh =====
// Assertion macros used by the checker file of the sketch.
`ifndef HLL_REGISTER_SKETCH_MACROS_SVH
`define HLL_REGISTER_SKETCH_MACROS_SVH

`define HLL_ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define HLL_ASSERT(label, prop, msg) \
  `HLL_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

// ===== design/hllrs_pkg.sv =====
// Shared types, widths and codes of the HyperLogLog register sketch.
package hllrs_pkg;

  localparam int unsigned IndexBitsDef = 12;
  localparam int unsigned HashW        = 32;
  localparam int unsigned OpW          = 2;
  localparam int unsigned MergeIdxW    = 12;
  localparam int unsigned RankW        = 5;
  localparam int unsigned SumW         = 45;
  localparam int unsigned ZeroW        = 13;
  localparam int unsigned FracBits     = 32;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned InDataW      = 56;
  localparam int unsigned OutDataW     = 64;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 2'd0,
    OP_MERGE = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_RUN   = 2'd1,
    ST_WALK  = 2'd2
  } state_e;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

// ===== design/hll_register_sketch.sv =====
// Top level of the HyperLogLog register sketch.
// Keeps 2^IndexBits five-bit rank registers in one memory with one write and one
// read port. Add and merge transfers are taken one per cycle unless the queue is full
// or the memory is being cleared, and update the memory through a two-stage
// read-modify-write pipeline with forwarding; opcode 3 is accepted and dropped. A query
// walks the memory one entry per cycle and its result is registered at the end of the
// walk; a query waits until the previous result has been taken. After reset the memory
// is cleared one entry per cycle while s_axis_tready_o stays low. A four-entry command
// queue lets the input side keep accepting while the back part stalls.
// Results: harmonic sum with 32 fraction bits and the count of zero registers, each
// saturated to its field width.
module hll_register_sketch import hllrs_pkg::*; #(
  parameter int unsigned IndexBits = IndexBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // hash[31:0], merge_index[43:32], merge_rank[48:44]
  input  logic [OpW-1:0]      s_axis_tuser_i,  // opcode[1:0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o   // harmonic_sum[44:0], zero_count[57:45]
);

  localparam int unsigned EntW = 1 + IndexBits + RankW;

  back_status_t     status;
  logic             q_push, q_full, q_pop, q_valid;
  logic [EntW-1:0]  q_wdata, q_rdata;
  logic [SumW-1:0]  res_sum;
  logic [ZeroW-1:0] res_zero;

  hllrs_front #(
    .IndexBits (IndexBits)
  ) u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .status_i   (status),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  hllrs_queue #(
    .Width (EntW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_rdata)
  );

  hllrs_back #(
    .IndexBits (IndexBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .status_o    (status),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_sum_o   (res_sum),
    .res_zero_o  (res_zero)
  );

  assign m_axis_tdata_o = {(OutDataW - SumW - ZeroW)'(0), res_zero, res_sum};

endmodule

// ===== design/hllrs_queue.sv =====
// Small command queue between the front and back parts.
module hllrs_queue import hllrs_pkg::*; #(
  parameter int unsigned Width = 18,
  parameter int unsigned Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/hllrs_front.sv =====
// Front part: accepts input transfers, computes index and rank, queues commands.
module hllrs_front import hllrs_pkg::*; #(
  parameter int unsigned IndexBits = IndexBitsDef,
  localparam int unsigned EntW     = 1 + IndexBits + RankW
) (
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  input  logic [InDataW-1:0] s_tdata_i,
  input  logic [OpW-1:0]     s_tuser_i,
  input  back_status_t       status_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output logic [EntW-1:0]    q_data_o
);

  localparam int unsigned RestW = HashW - IndexBits;

  logic [HashW-1:0]     hash;
  logic [MergeIdxW-1:0] merge_index;
  logic [RankW-1:0]     merge_rank;
  logic [RestW-1:0]     rest;
  logic [RankW-1:0]     hash_rank;
  logic [IndexBits-1:0] idx;
  logic [RankW-1:0]     rank;
  cmd_e                 kind;
  logic                 keep;
  logic                 xfer;

  assign hash        = s_tdata_i[HashW-1:0];
  assign merge_index = s_tdata_i[HashW +: MergeIdxW];
  assign merge_rank  = s_tdata_i[HashW + MergeIdxW +: RankW];
  assign rest        = hash[RestW-1:0];

  // leading zeros of the low hash bits plus one; highest set bit wins
  always_comb begin
    hash_rank = RankW'(RestW + 1);
    for (int i = 0; i < RestW; i++) begin
      if (rest[i]) begin
        hash_rank = RankW'(RestW - i);
      end
    end
  end

  always_comb begin
    kind = CMD_UPDATE;
    idx  = hash[HashW-1 -: IndexBits];
    rank = hash_rank;
    keep = 1'b1;
    unique case (s_tuser_i)
      OP_ADD: begin
        kind = CMD_UPDATE;
      end
      OP_MERGE: begin
        idx  = IndexBits'(merge_index);
        rank = merge_rank;
      end
      OP_QUERY: begin
        kind = CMD_QUERY;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign s_tready_o = !q_full_i && !status_i.clearing;
  assign xfer       = s_tvalid_i && s_tready_o;
  assign q_push_o   = xfer && keep;
  assign q_data_o   = {kind, idx, rank};

endmodule

// ===== design/hllrs_back.sv =====
// Back part: rank memory, read-modify-write pipeline, query walk and result register.
module hllrs_back import hllrs_pkg::*; #(
  parameter int unsigned IndexBits = IndexBitsDef,
  localparam int unsigned EntW     = 1 + IndexBits + RankW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  logic [EntW-1:0]  q_data_i,
  output logic             q_pop_o,
  output back_status_t     status_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic [SumW-1:0]  res_sum_o,
  output logic [ZeroW-1:0] res_zero_o
);

  localparam int unsigned AccW  = IndexBits + FracBits + 1;
  localparam int unsigned CntW  = IndexBits + 1;
  localparam int unsigned SCmpW = (AccW > SumW) ? AccW : SumW;
  localparam int unsigned ZCmpW = (CntW > ZeroW) ? CntW : ZeroW;
  localparam int unsigned ShW   = $clog2(FracBits + 1);

  logic [RankW-1:0]     rank_mem [2**IndexBits];

  state_e               state_q, state_d;
  logic [IndexBits-1:0] ctr_q, ctr_d;

  cmd_e                 head_kind;
  logic [IndexBits-1:0] head_idx;
  logic [RankW-1:0]     head_rank;

  logic                 iss_valid, iss_walk, iss_last;
  logic [IndexBits-1:0] iss_idx;

  logic                 s1_valid_q, s1_walk_q, s1_last_q;
  logic [IndexBits-1:0] s1_idx_q;
  logic [RankW-1:0]     s1_rank_q;
  logic [RankW-1:0]     rdata_q;

  logic                 fwd_valid_q;
  logic [IndexBits-1:0] fwd_idx_q;
  logic [RankW-1:0]     fwd_val_q;

  logic [RankW-1:0]     cur;
  logic [RankW-1:0]     new_val;
  logic                 wr_en;
  logic [IndexBits-1:0] wr_addr;
  logic [RankW-1:0]     wr_data;

  logic [ShW-1:0]       shamt;
  logic [AccW-1:0]      term, sum_next;
  logic [CntW-1:0]      zero_next;
  logic [SCmpW-1:0]     sum_ext;
  logic [ZCmpW-1:0]     zero_ext;
  logic [AccW-1:0]      acc_sum_q;
  logic [CntW-1:0]      acc_zero_q;

  logic                 out_valid_q;
  logic [SumW-1:0]      out_sum_q;
  logic [ZeroW-1:0]     out_zero_q;
  logic                 walk_done;

  assign head_kind = cmd_e'(q_data_i[EntW-1]);
  assign head_idx  = q_data_i[RankW +: IndexBits];
  assign head_rank = q_data_i[RankW-1:0];

  always_comb begin
    state_d   = state_q;
    ctr_d     = ctr_q;
    q_pop_o   = 1'b0;
    iss_valid = 1'b0;
    iss_walk  = 1'b0;
    iss_last  = 1'b0;
    iss_idx   = head_idx;
    unique case (state_q)
      ST_CLEAR: begin
        ctr_d = ctr_q + IndexBits'(1);
        if (ctr_q == '1) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (q_valid_i) begin
          unique case (head_kind)
            CMD_UPDATE: begin
              q_pop_o   = 1'b1;
              iss_valid = 1'b1;
            end
            CMD_QUERY: begin
              // start a walk only once the previous result has left
              if (!out_valid_q && !(s1_valid_q && s1_walk_q)) begin
                q_pop_o = 1'b1;
                ctr_d   = '0;
                state_d = ST_WALK;
              end
            end
          endcase
        end
      end
      ST_WALK: begin
        iss_valid = 1'b1;
        iss_walk  = 1'b1;
        iss_idx   = ctr_q;
        iss_last  = (ctr_q == '1);
        ctr_d     = ctr_q + IndexBits'(1);
        if (ctr_q == '1) begin
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // the read at this edge missed the write of the previous entry: forward it
  assign cur     = (fwd_valid_q && (fwd_idx_q == s1_idx_q)) ? fwd_val_q : rdata_q;
  assign new_val = (s1_rank_q > cur) ? s1_rank_q : cur;

  assign wr_en   = (state_q == ST_CLEAR) || (s1_valid_q && !s1_walk_q);
  assign wr_addr = (state_q == ST_CLEAR) ? ctr_q : s1_idx_q;
  assign wr_data = (state_q == ST_CLEAR) ? '0 : new_val;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rank_mem[wr_addr] <= wr_data;
    end
    if (iss_valid) begin
      rdata_q <= rank_mem[iss_idx];
    end
  end

  assign shamt     = ShW'(FracBits) - ShW'(cur);
  assign term      = AccW'(1) << shamt;
  assign sum_next  = acc_sum_q + term;
  assign zero_next = acc_zero_q + CntW'(cur == '0);
  assign sum_ext   = SCmpW'(sum_next);
  assign zero_ext  = ZCmpW'(zero_next);
  assign walk_done = s1_valid_q && s1_walk_q && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ctr_q       <= '0;
      s1_valid_q  <= 1'b0;
      s1_walk_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
      acc_sum_q   <= '0;
      acc_zero_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      s1_valid_q  <= iss_valid;
      s1_walk_q   <= iss_valid && iss_walk;
      fwd_valid_q <= s1_valid_q && !s1_walk_q;
      if (s1_valid_q && s1_walk_q) begin
        if (s1_last_q) begin
          acc_sum_q  <= '0;
          acc_zero_q <= '0;
        end else begin
          acc_sum_q  <= sum_next;
          acc_zero_q <= zero_next;
        end
      end
      if (out_valid_q && res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (walk_done) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= iss_last;
    s1_idx_q  <= iss_idx;
    s1_rank_q <= head_rank;
    fwd_idx_q <= s1_idx_q;
    fwd_val_q <= new_val;
    if (walk_done) begin
      out_sum_q  <= (sum_ext > SCmpW'({SumW{1'b1}})) ? '1 : sum_ext[SumW-1:0];
      out_zero_q <= (zero_ext > ZCmpW'({ZeroW{1'b1}})) ? '1 : zero_ext[ZeroW-1:0];
    end
  end

  assign status_o.clearing = (state_q == ST_CLEAR);
  assign res_valid_o       = out_valid_q;
  assign res_sum_o         = out_sum_q;
  assign res_zero_o        = out_zero_q;

endmodule

// ===== design/hllrs_checker.sv =====
// Port-level checker of the sketch and its bind to the top level.
`include "hll_register_sketch_macros.svh"

module hllrs_checker import hllrs_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  `HLL_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result dropped while stalled")
  `HLL_ASSERT(a_out_stable, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o), "result changed while stalled")
  `HLL_ASSERT(a_sum_covers_zeros, m_axis_tvalid_o |-> m_axis_tdata_o[44:32] >= m_axis_tdata_o[57:45], "harmonic sum below zero register count")

endmodule

bind hll_register_sketch hllrs_checker u_chk (.*);

// ===== test/tb_hll_register_sketch.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the HyperLogLog register sketch with a rank-bank predictor.
module tb_hll_register_sketch;
  import hllrs_pkg::*;

  localparam int unsigned NumRegs = 1 << IndexBitsDef;
  localparam int unsigned RestW   = HashW - IndexBitsDef;
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int unsigned RandomItems = 800;
  localparam int unsigned MaxRandomQueries = 30;

  typedef struct packed {
    logic [SumW-1:0]  sum;
    logic [ZeroW-1:0] zeros;
  } tally_t;

  class sketch_scoreboard;
    logic [RankW-1:0] rank_bank [NumRegs];
    tally_t           tally_q [$];
    int unsigned      errors;
    int unsigned      results;

    function new();
      foreach (rank_bank[i]) rank_bank[i] = '0;
      errors  = 0;
      results = 0;
    endfunction

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("mismatch: %s", what);
    endfunction

    function void raise_rank(logic [IndexBitsDef-1:0] idx, logic [RankW-1:0] rank);
      if (rank > rank_bank[idx]) rank_bank[idx] = rank;
    endfunction

    function void note_transfer(logic [OpW-1:0] op, logic [HashW-1:0] hash,
                                logic [MergeIdxW-1:0] idx, logic [RankW-1:0] rank);
      logic [RestW-1:0] rest;
      logic [RankW-1:0] hash_rank;
      logic [63:0]      acc;
      int unsigned      zeros;
      tally_t           want;
      if (op == OP_ADD) begin
        rest = hash[RestW-1:0];
        hash_rank = RankW'(RestW + 1);
        for (int b = 0; b < RestW; b++)
          if (rest[b]) hash_rank = RankW'(RestW - b);
        raise_rank(hash[HashW-1 -: IndexBitsDef], hash_rank);
      end else if (op == OP_MERGE) begin
        raise_rank(idx[IndexBitsDef-1:0], rank);
      end else if (op == OP_QUERY) begin
        acc   = '0;
        zeros = 0;
        foreach (rank_bank[i]) begin
          acc += 64'd1 << (FracBits - rank_bank[i]);
          if (rank_bank[i] == '0) zeros++;
        end
        want.sum   = (acc > {SumW{1'b1}}) ? {SumW{1'b1}} : acc[SumW-1:0];
        want.zeros = (zeros > {ZeroW{1'b1}}) ? {ZeroW{1'b1}} : zeros[ZeroW-1:0];
        tally_q.push_back(want);
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      tally_t got;
      tally_t want;
      got.sum   = data[SumW-1:0];
      got.zeros = data[SumW+ZeroW-1:SumW];
      results++;
      if (tally_q.size() == 0) begin
        flag($sformatf("unexpected result sum=%h zeros=%0d", got.sum, got.zeros));
        return;
      end
      want = tally_q.pop_front();
      if (got.sum != want.sum)
        flag($sformatf("harmonic_sum expected %h got %h", want.sum, got.sum));
      if (got.zeros != want.zeros)
        flag($sformatf("zero_count expected %0d got %0d", want.zeros, got.zeros));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic [OpW-1:0]      s_axis_tuser_i = OP_ADD;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  sketch_scoreboard sb = new();
  bit               calm = 1'b0;
  int unsigned      stall_left = 0;
  int unsigned      n_add = 0, n_merge = 0, n_query = 0, n_ignored = 0;
  logic [IndexBitsDef-1:0] hot_idx [8] = '{0, 1, 7, 8, 100, 2047, 2048, 4095};

  hll_register_sketch u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  task automatic send_op(logic [OpW-1:0] op, logic [HashW-1:0] hash,
                         logic [MergeIdxW-1:0] idx, logic [RankW-1:0] rank);
    int unsigned gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {{(InDataW-RankW-MergeIdxW-HashW){1'b0}}, rank, idx, hash};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_transfer(op, hash, idx, rank);
    case (op)
      OP_ADD:   n_add++;
      OP_MERGE: n_merge++;
      OP_QUERY: n_query++;
      default:  n_ignored++;
    endcase
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (sb.tally_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(int unsigned queries_left);
    int unsigned      pick;
    logic [HashW-1:0] hash;
    logic [RestW-1:0] rest;
    logic [MergeIdxW-1:0] idx;
    pick = $urandom_range(0, 99);
    hash = $urandom;
    idx  = MergeIdxW'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      hash[HashW-1 -: IndexBitsDef] = hot_idx[$urandom_range(0, 7)];
      idx = hot_idx[$urandom_range(0, 7)];
    end
    rest = hash[RestW-1:0] >> $urandom_range(0, RestW);
    if ($urandom_range(0, 1) == 0) hash[RestW-1:0] = rest;
    if (pick < 3 && queries_left > 0)
      send_op(OP_QUERY, hash, idx, RankW'($urandom));
    else if (pick < 8)
      send_op(OpUnused, hash, idx, RankW'($urandom));
    else if (pick < 40)
      send_op(OP_MERGE, hash, idx, RankW'($urandom_range(0, 31)));
    else
      send_op(OP_ADD, hash, idx, RankW'($urandom));
  endtask

  initial begin
    int unsigned rand_queries;
    rand_queries = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_op(OP_QUERY, 32'h0, '0, '0);
    send_op(OP_ADD, 32'h0000_0000, '0, '0);
    send_op(OP_ADD, 32'hFFFF_FFFF, '1, '1);
    send_op(OP_ADD, 32'h0000_0001, '0, '0);
    send_op(OP_ADD, 32'h7FF8_0000, '0, '0);
    send_op(OP_ADD, 32'hABC0_0001, '0, '0);
    send_op(OP_MERGE, 32'h0, 12'd4095, 5'd31);
    send_op(OP_MERGE, '1, 12'd5, 5'd0);
    send_op(OP_MERGE, 32'h0, 12'd0, 5'd3);
    send_op(OP_MERGE, 32'h0, 12'd1, 5'd31);
    send_op(OP_ADD, 32'h0010_0000, '0, '0);
    send_op(OpUnused, '1, '1, '1);
    send_op(OP_ADD, 32'h0078_0000, '0, '0);
    send_op(OP_ADD, 32'h0070_8000, '0, '0);
    send_op(OP_ADD, 32'h0072_0000, '0, '0);
    send_op(OP_ADD, 32'h0070_0100, '0, '0);
    send_op(OP_MERGE, 32'h0, 12'd7, 5'd30);
    send_op(OP_ADD, 32'h0070_0000, '0, '0);
    send_op(OP_MERGE, '1, 12'd2730, 5'd21);
    send_op(OP_QUERY, '1, '1, '1);
    send_op(OP_QUERY, 32'h0, '0, '0);

    drain_results();

    for (int unsigned i = 0; i < RandomItems; i++) begin
      calm = (i >= 300 && i < 380) || (i >= RandomItems - 120);
      if (s_axis_tuser_i == OP_QUERY && s_axis_tvalid_i) rand_queries++;
      send_random(MaxRandomQueries - rand_queries);
    end
    send_op(OP_QUERY, $urandom, MergeIdxW'($urandom), RankW'($urandom));
    s_axis_tvalid_i <= 1'b0;

    while (sb.tally_q.size() != 0) @(posedge clk_i);
    repeat (NumRegs + 32) @(posedge clk_i);

    $display("covered %0d adds, %0d merges, %0d queries, %0d ignored opcodes",
             n_add, n_merge, n_query, n_ignored);
    $display("checked %0d sketch results, %0d mismatches", sb.results, sb.errors);
    if (sb.errors == 0 && sb.tally_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", sb.tally_q.size());
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/hllrs_pkg.sv
design/hllrs_queue.sv
design/hllrs_front.sv
design/hllrs_back.sv
design/hll_register_sketch.sv
design/hllrs_checker.sv
test/tb_hll_register_sketch.sv
